[rtl/core/ntg_pkg.sv]
`default_nettype none

package ntg_pkg;

  // Field widths of the input and result beats.
  localparam int unsigned OP_W     = 1;
  localparam int unsigned KEY_W    = 7;
  localparam int unsigned VEL_W    = 7;
  localparam int unsigned SAMPLE_W = 10;

  // Tone state widths.
  localparam int unsigned FREQ_W  = 16;
  localparam int unsigned IDX_W   = 16;
  localparam int unsigned QUAD_W  = 2;
  localparam int unsigned INC_INT = 8;   // integer bits of the phase increment

  // Opcodes of the op field.
  localparam logic [OP_W-1:0] OP_NOTE = 1'b0;
  localparam logic [OP_W-1:0] OP_TICK = 1'b1;

  // Semitone table and octave split of the key.
  localparam int unsigned SEMI_W       = 6;
  localparam int unsigned SEMI_IDX_W   = 4;
  localparam int unsigned OCT_W        = 4;
  localparam int unsigned NOTE_PER_OCT = 12;
  // key / 12 equals (key * 43) >> 9 for every 7-bit key.
  localparam int unsigned OCT_RECIP_W  = 6;
  localparam int unsigned OCT_RECIP    = 43;
  localparam int unsigned OCT_SHIFT    = 9;

  // Increment = f * 628 * 2^FRAC / 500000 = (f * 628 << (FRAC - 5)) / 15625.
  localparam int unsigned FREQ_MUL_W = 10;
  localparam int unsigned FREQ_MUL   = 628;
  localparam int unsigned DIV_SHIFT  = 5;
  localparam int unsigned DIVISOR_W  = 14;
  localparam int unsigned DIVISOR    = 15625;
  localparam int unsigned RESET_HZ   = 440;

  // Output scaling.
  localparam int unsigned SCALE_W    = 16;
  localparam int unsigned LEVEL_GAIN = 510;
  localparam int unsigned OUT_SHIFT  = 6;
  localparam int unsigned SAMPLE_MAX = 1023;

  // Command queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_NOTE_SET,
    CMD_NOTE_RECALC
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e           kind;
    logic [VEL_W-1:0]    level;
    logic [FREQ_W-1:0]   freq;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_rsp_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_SQUARE,
    BK_CUBE,
    BK_RECIP,
    BK_CORRECT,
    BK_SHAPE,
    BK_SCALE,
    BK_NOTE
  } back_state_e;

  // Integer Hz of the lowest octave, one entry per semitone.
  function automatic logic [SEMI_W-1:0] semitone_hz(input logic [SEMI_IDX_W-1:0] idx);
    logic [SEMI_W-1:0] hz;
    case (idx)
      4'd0:    hz = 6'd32;
      4'd1:    hz = 6'd34;
      4'd2:    hz = 6'd36;
      4'd3:    hz = 6'd38;
      4'd4:    hz = 6'd41;
      4'd5:    hz = 6'd43;
      4'd6:    hz = 6'd46;
      4'd7:    hz = 6'd49;
      4'd8:    hz = 6'd51;
      4'd9:    hz = 6'd55;
      4'd10:   hz = 6'd58;
      4'd11:   hz = 6'd61;
      default: hz = '0;
    endcase
    return hz;
  endfunction

endpackage

`default_nettype wire

[rtl/core/ntg_front.sv]
`default_nettype none

module ntg_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      valid_i,
  input  wire logic [ntg_pkg::OP_W-1:0]  op_i,
  input  wire logic [ntg_pkg::KEY_W-1:0] key_i,
  input  wire logic [ntg_pkg::VEL_W-1:0] velocity_i,
  input  wire logic                      full_i,
  output logic                           push_o,
  output ntg_pkg::cmd_t                  cmd_o
);

  logic [ntg_pkg::KEY_W-1:0]                        held_key_q, held_key_d;
  logic                                             key_match;
  logic [ntg_pkg::KEY_W+ntg_pkg::OCT_RECIP_W-1:0]   oct_prod;
  logic [ntg_pkg::OCT_W-1:0]                        octave;
  logic [ntg_pkg::KEY_W-1:0]                        oct_base;
  logic [ntg_pkg::KEY_W-1:0]                        semi_idx;
  logic [ntg_pkg::FREQ_W-1:0]                       note_freq;

  // A beat is taken whenever the queue has room.
  assign push_o = valid_i && !full_i;

  // Split the key into octave and semitone without a divider.
  assign oct_prod  = ntg_pkg::KEY_W'(key_i) * ntg_pkg::OCT_RECIP_W'(ntg_pkg::OCT_RECIP);
  assign octave    = oct_prod[ntg_pkg::OCT_SHIFT +: ntg_pkg::OCT_W];
  assign oct_base  = ntg_pkg::KEY_W'(octave) * ntg_pkg::KEY_W'(ntg_pkg::NOTE_PER_OCT);
  assign semi_idx  = key_i - oct_base;
  assign note_freq = ntg_pkg::FREQ_W'(ntg_pkg::semitone_hz(semi_idx[ntg_pkg::SEMI_IDX_W-1:0]))
                     << octave;

  // A pressed key always becomes the held key, so it always matches.
  assign key_match = (velocity_i != '0) || (key_i == held_key_q);

  // Classify the beat into a command for the back end.
  always_comb begin
    cmd_o.level = velocity_i;
    cmd_o.freq  = note_freq;
    if (op_i == ntg_pkg::OP_TICK) begin
      cmd_o.kind = ntg_pkg::CMD_TICK;
    end else if (key_match) begin
      cmd_o.kind = ntg_pkg::CMD_NOTE_SET;
    end else begin
      cmd_o.kind = ntg_pkg::CMD_NOTE_RECALC;
    end
  end

  // Held key tracking.
  always_comb begin
    held_key_d = held_key_q;
    if (push_o && (op_i == ntg_pkg::OP_NOTE) && (velocity_i != '0)) begin
      held_key_d = key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_key_q <= '0;
    end else begin
      held_key_q <= held_key_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/ntg_queue.sv]
`default_nettype none

module ntg_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire ntg_pkg::cmd_t cmd_i,
  input  wire logic          pop_i,
  output ntg_pkg::cmd_t      cmd_o,
  output ntg_pkg::queue_status_t status_o
);

  ntg_pkg::cmd_t                    entry_q [ntg_pkg::QUEUE_DEPTH];
  logic [ntg_pkg::QUEUE_PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [ntg_pkg::QUEUE_PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [ntg_pkg::QUEUE_CNT_W-1:0]  count_q, count_d;

  assign cmd_o           = entry_q[rd_ptr_q];
  assign status_o.full   = (count_q == ntg_pkg::QUEUE_CNT_W'(ntg_pkg::QUEUE_DEPTH));
  assign status_o.empty  = (count_q == '0);

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + ntg_pkg::QUEUE_PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + ntg_pkg::QUEUE_PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + ntg_pkg::QUEUE_CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - ntg_pkg::QUEUE_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

[rtl/core/ntg_div.sv]
`default_nettype none

module ntg_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  input  wire logic                                     start_i,
  input  wire logic [ntg_pkg::FREQ_W-1:0]               freq_i,
  output ntg_pkg::div_rsp_t                             rsp_o,
  output logic [FRAC_BITS+ntg_pkg::INC_INT-1:0]         quot_o
);

  localparam int unsigned INC_W  = FRAC_BITS + ntg_pkg::INC_INT;
  localparam int unsigned FM_W   = ntg_pkg::FREQ_W + ntg_pkg::FREQ_MUL_W;
  localparam int unsigned PAD_W  = FRAC_BITS - ntg_pkg::DIV_SHIFT;
  localparam int unsigned NUM_W  = FM_W + PAD_W;
  // The reciprocal carries FM_W extra fraction bits, so for any dividend the
  // estimate is either the quotient or one below it.
  localparam int unsigned RCP_S  = FM_W;
  localparam int unsigned RCP_W  = PAD_W + RCP_S + 1 - ntg_pkg::DIVISOR_W;
  localparam int unsigned PROD_W = FM_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP = RCP_W'((64'd1 << (PAD_W + RCP_S))
                                          / 64'(ntg_pkg::DIVISOR));

  logic [FM_W-1:0]   freq_mul_q;
  logic [INC_W-1:0]  est_q;
  logic [INC_W-1:0]  quot_q;
  logic              mul_vld_q;
  logic              est_vld_q;
  logic              done_q;
  logic [PROD_W-1:0] prod;
  logic [NUM_W-1:0]  num;
  logic [NUM_W-1:0]  rem;
  logic              short;

  // Estimate of the quotient by multiplying with the scaled reciprocal.
  assign prod = PROD_W'(freq_mul_q) * PROD_W'(RCP);

  // The remainder of the estimate shows whether one more divisor fits.
  assign num   = {freq_mul_q, {PAD_W{1'b0}}};
  assign rem   = num - (NUM_W'(est_q) * NUM_W'(ntg_pkg::DIVISOR));
  assign short = (rem >= NUM_W'(ntg_pkg::DIVISOR));

  // Three steps: scale the frequency, estimate, correct.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
      est_vld_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      mul_vld_q <= start_i;
      est_vld_q <= mul_vld_q;
      done_q    <= est_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      freq_mul_q <= FM_W'(freq_i) * FM_W'(ntg_pkg::FREQ_MUL);
    end
    if (mul_vld_q) begin
      est_q <= prod[RCP_S +: INC_W];
    end
    if (est_vld_q) begin
      quot_q <= est_q + INC_W'(short);
    end
  end

  assign rsp_o.busy = mul_vld_q || est_vld_q;
  assign rsp_o.done = done_q;
  assign quot_o     = quot_q;

endmodule

`default_nettype wire

[rtl/core/ntg_back.sv]
`default_nettype none

module ntg_back #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cmd_valid_i,
  input  wire ntg_pkg::cmd_t                        cmd_i,
  output logic                                      pop_o,
  output logic                                      div_start_o,
  output logic [ntg_pkg::FREQ_W-1:0]                div_freq_o,
  input  wire ntg_pkg::div_rsp_t                    div_rsp_i,
  input  wire logic [FRAC_BITS+ntg_pkg::INC_INT-1:0] div_quot_i,
  output logic                                      valid_o,
  input  wire logic                                 stall_i,
  output logic [ntg_pkg::SAMPLE_W-1:0]              sample_o
);

  localparam int unsigned INC_W    = FRAC_BITS + ntg_pkg::INC_INT;
  localparam int unsigned X_W      = INC_W + ntg_pkg::IDX_W;
  localparam int unsigned XS_W     = FRAC_BITS + 2;   // x below 2.5
  localparam int unsigned X2_W     = FRAC_BITS + 3;   // x^2 below 6.25
  localparam int unsigned X3_W     = FRAC_BITS + 4;   // x^3 below 15.7
  localparam int unsigned Y_W      = X3_W - 1;        // x^3 / 2
  localparam int unsigned RECIP_K  = FRAC_BITS + 4;
  localparam int unsigned RECIP_W  = FRAC_BITS + 3;
  localparam int unsigned RP_W     = Y_W + RECIP_W;
  localparam int unsigned P_W      = FRAC_BITS + 1;
  localparam int unsigned B_W      = FRAC_BITS + 2;
  localparam int unsigned PROD_W   = B_W + ntg_pkg::SCALE_W;
  localparam int unsigned VAL_W    = PROD_W - FRAC_BITS - ntg_pkg::OUT_SHIFT;

  localparam logic [X_W-1:0]     BIG_Q     = X_W'(64'd5 << (FRAC_BITS - 1));
  localparam logic [X_W-1:0]     TURN_Q    = X_W'((64'd156 << FRAC_BITS) / 64'd100);
  localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'((64'd1 << RECIP_K) / 64'd3);
  localparam logic [INC_W-1:0]   INC_RESET = INC_W'(((64'd440 * 64'd628) << FRAC_BITS)
                                                    / 64'd500000);
  localparam logic [P_W-1:0]     ONE_P     = P_W'(64'd1 << FRAC_BITS);
  localparam logic [B_W-1:0]     ONE_B     = B_W'(64'd1 << FRAC_BITS);
  localparam logic [B_W-1:0]     TWO_B     = B_W'(64'd2 << FRAC_BITS);

  ntg_pkg::back_state_e state_q, state_d;

  // Tone state.
  logic [INC_W-1:0]               inc_q;
  logic [ntg_pkg::IDX_W-1:0]      idx_q;
  logic [ntg_pkg::QUAD_W-1:0]     quad_q;
  logic [ntg_pkg::FREQ_W-1:0]     freq_q;
  logic [ntg_pkg::SCALE_W-1:0]    scale_q;   // level times the output gain

  // Sample datapath.
  logic [X_W-1:0]                 x_q;
  logic                           big_q, turn_q;
  logic [X2_W-1:0]                x2_q;
  logic [X3_W-1:0]                x3_q;
  logic [RP_W-1:0]                rp_q;
  logic [XS_W-1:0]                c_q;
  logic [B_W-1:0]                 biased_q;
  logic [ntg_pkg::SAMPLE_W-1:0]   sample_q;
  logic                           valid_q;

  logic                           out_free;
  logic                           take_tick, take_set, load_inc, emit;
  logic [XS_W-1:0]                xs;
  logic [2*XS_W-1:0]              sq;
  logic [X2_W+XS_W-1:0]           cu;
  logic [Y_W-1:0]                 y;
  logic [XS_W-1:0]                q0;
  logic [Y_W-1:0]                 r;
  logic [XS_W-1:0]                c_d;
  logic [XS_W-1:0]                diff;
  logic [P_W-1:0]                 p;
  logic [B_W-1:0]                 biased_d;
  logic [PROD_W-1:0]              prod;
  logic [VAL_W-1:0]               val;
  logic [ntg_pkg::SAMPLE_W-1:0]   sat;

  assign out_free = !valid_q || !stall_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ntg_pkg::BK_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.kind)
            ntg_pkg::CMD_TICK:                                state_d = ntg_pkg::BK_SQUARE;
            ntg_pkg::CMD_NOTE_SET, ntg_pkg::CMD_NOTE_RECALC:  state_d = ntg_pkg::BK_NOTE;
            default:                                          state_d = ntg_pkg::BK_IDLE;
          endcase
        end
      end
      ntg_pkg::BK_SQUARE:  state_d = ntg_pkg::BK_CUBE;
      ntg_pkg::BK_CUBE:    state_d = ntg_pkg::BK_RECIP;
      ntg_pkg::BK_RECIP:   state_d = ntg_pkg::BK_CORRECT;
      ntg_pkg::BK_CORRECT: state_d = ntg_pkg::BK_SHAPE;
      ntg_pkg::BK_SHAPE:   state_d = ntg_pkg::BK_SCALE;
      ntg_pkg::BK_SCALE: begin
        if (out_free) begin
          state_d = ntg_pkg::BK_IDLE;
        end
      end
      ntg_pkg::BK_NOTE: begin
        if (div_rsp_i.done) begin
          state_d = ntg_pkg::BK_IDLE;
        end
      end
      default: state_d = ntg_pkg::BK_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    pop_o       = 1'b0;
    div_start_o = 1'b0;
    div_freq_o  = freq_q;
    take_tick   = 1'b0;
    take_set    = 1'b0;
    load_inc    = 1'b0;
    emit        = 1'b0;
    case (state_q)
      ntg_pkg::BK_IDLE: begin
        pop_o = cmd_valid_i;
        case (cmd_i.kind)
          ntg_pkg::CMD_TICK: begin
            take_tick = cmd_valid_i;
          end
          ntg_pkg::CMD_NOTE_SET: begin
            take_set    = cmd_valid_i;
            div_start_o = cmd_valid_i;
            div_freq_o  = cmd_i.freq;
          end
          ntg_pkg::CMD_NOTE_RECALC: begin
            div_start_o = cmd_valid_i;
          end
          default: begin
          end
        endcase
      end
      ntg_pkg::BK_SCALE: emit     = out_free;
      ntg_pkg::BK_NOTE:  load_inc = div_rsp_i.done;
      default: begin
      end
    endcase
  end

  // Polynomial datapath: x^2, x^3, x^3/6 by reciprocal, then shape.
  assign xs = x_q[XS_W-1:0];
  assign sq = (2*XS_W)'(xs) * (2*XS_W)'(xs);
  assign cu = (X2_W+XS_W)'(x2_q) * (X2_W+XS_W)'(xs);
  assign y  = x3_q[X3_W-1:1];
  assign q0 = rp_q[RECIP_K +: XS_W];
  assign r  = y - (Y_W'({q0, 1'b0}) + Y_W'(q0));
  assign c_d = (r >= Y_W'(3)) ? (q0 + XS_W'(1)) : q0;

  // Quarter sine, clamped to 0..1, mapped to the quadrant with a bias of one.
  assign diff = xs - c_q;
  always_comb begin
    if (big_q || (c_q >= xs)) begin
      p = '0;
    end else if (diff > XS_W'(ONE_P)) begin
      p = ONE_P;
    end else begin
      p = diff[P_W-1:0];
    end
    case (quad_q)
      2'd0:    biased_d = ONE_B + B_W'(p);
      2'd1:    biased_d = TWO_B - B_W'(p);
      2'd2:    biased_d = ONE_B - B_W'(p);
      default: biased_d = B_W'(p);
    endcase
  end

  // Level scaling and saturation.
  assign prod = PROD_W'(biased_q) * PROD_W'(scale_q);
  assign val  = prod[PROD_W-1 -: VAL_W];
  assign sat  = (val > VAL_W'(ntg_pkg::SAMPLE_MAX)) ? ntg_pkg::SAMPLE_W'(ntg_pkg::SAMPLE_MAX)
                                                   : val[ntg_pkg::SAMPLE_W-1:0];

  // Sequencer and tone state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ntg_pkg::BK_IDLE;
      inc_q   <= INC_RESET;
      idx_q   <= '0;
      quad_q  <= '0;
      freq_q  <= ntg_pkg::FREQ_W'(1);
      scale_q <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (take_set) begin
        freq_q  <= cmd_i.freq;
        scale_q <= ntg_pkg::SCALE_W'(cmd_i.level) * ntg_pkg::SCALE_W'(ntg_pkg::LEVEL_GAIN);
      end
      if (load_inc) begin
        inc_q <= div_quot_i;
      end
      if (emit) begin
        valid_q <= 1'b1;
        if (turn_q) begin
          quad_q <= quad_q + ntg_pkg::QUAD_W'(1);
          idx_q  <= ntg_pkg::IDX_W'(1);
        end else begin
          idx_q  <= idx_q + ntg_pkg::IDX_W'(1);
        end
      end else if (!stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers, one stage of work per state.
  always_ff @(posedge clk_i) begin
    if (take_tick) begin
      x_q <= X_W'(inc_q) * X_W'(idx_q);
    end
    if (state_q == ntg_pkg::BK_SQUARE) begin
      big_q  <= (x_q > BIG_Q);
      turn_q <= (x_q > TURN_Q);
      x2_q   <= sq[FRAC_BITS +: X2_W];
    end
    if (state_q == ntg_pkg::BK_CUBE) begin
      x3_q <= cu[FRAC_BITS +: X3_W];
    end
    if (state_q == ntg_pkg::BK_RECIP) begin
      rp_q <= RP_W'(y) * RP_W'(RECIP);
    end
    if (state_q == ntg_pkg::BK_CORRECT) begin
      c_q <= c_d;
    end
    if (state_q == ntg_pkg::BK_SHAPE) begin
      biased_q <= biased_d;
    end
    if (emit) begin
      sample_q <= sat;
    end
  end

  assign valid_o  = valid_q;
  assign sample_o = sample_q;

endmodule

`default_nettype wire

[rtl/core/note_driven_sine_tone_generator.sv]
`default_nettype none

// Note-driven sine tone generator. Each input beat is either a note message
// or a sample tick; a tick returns one 10-bit DAC sample, a note returns
// nothing and retunes the tone. Input beats are classified on arrival and
// placed in a two-entry command queue, so while the queue has room the input
// keeps taking beats while the sample engine works or while a finished sample
// waits on the output register. A tick occupies the sample engine through a
// sequence of multiply or compare steps (phase, square, cube, divide by
// six in two steps, shape, scale) and for as long as the result waits on a
// stalled output. A note occupies it while it takes the command and while the
// divider turns the note frequency into a phase step (scale by 628,
// reciprocal-multiply estimate, one-step correction).
// The phase and polynomial use FRAC_BITS fractional bits.
module note_driven_sine_tone_generator #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [ntg_pkg::OP_W-1:0]     op_i,
  input  wire logic [ntg_pkg::KEY_W-1:0]    key_i,
  input  wire logic [ntg_pkg::VEL_W-1:0]    velocity_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [ntg_pkg::SAMPLE_W-1:0]      sample_o
);

  localparam int unsigned INC_W = FRAC_BITS + ntg_pkg::INC_INT;

  logic                           push;
  logic                           pop;
  ntg_pkg::cmd_t                  front_cmd;
  ntg_pkg::cmd_t                  head_cmd;
  ntg_pkg::queue_status_t         q_status;
  logic                           div_start;
  logic [ntg_pkg::FREQ_W-1:0]     div_freq;
  ntg_pkg::div_rsp_t              div_rsp;
  logic [INC_W-1:0]               div_quot;

  assign in_stall_o = q_status.full;

  ntg_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (in_valid_i),
    .op_i       (op_i),
    .key_i      (key_i),
    .velocity_i (velocity_i),
    .full_i     (q_status.full),
    .push_o     (push),
    .cmd_o      (front_cmd)
  );

  ntg_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (front_cmd),
    .pop_i    (pop),
    .cmd_o    (head_cmd),
    .status_o (q_status)
  );

  ntg_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .freq_i  (div_freq),
    .rsp_o   (div_rsp),
    .quot_o  (div_quot)
  );

  ntg_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!q_status.empty),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .div_start_o (div_start),
    .div_freq_o  (div_freq),
    .div_rsp_i   (div_rsp),
    .div_quot_i  (div_quot),
    .valid_o     (out_valid_o),
    .stall_i     (out_stall_i),
    .sample_o    (sample_o)
  );

  // The queue is never written while full.
  a_queue_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status.full |-> !push)
    else $error("command queue written while full");

  // The back end only takes a command that is there.
  a_queue_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty)
    else $error("command queue read while empty");

  // A new division never starts on top of one in flight.
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  // The divider never reports done while it is still busy.
  a_div_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> !div_rsp.busy)
    else $error("divider reported done while still busy");

endmodule

`default_nettype wire

[tb/sv/tone_sample_checker.sv]
`default_nettype none

// Watches both channels of the tone generator, keeps its own copy of the
// tone state, predicts the sample of every tick beat and compares it with
// the result beats in order.
module tone_sample_checker #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  input  wire logic                         in_stall_i,
  input  wire logic [ntg_pkg::OP_W-1:0]     op_i,
  input  wire logic [ntg_pkg::KEY_W-1:0]    key_i,
  input  wire logic [ntg_pkg::VEL_W-1:0]    velocity_i,
  input  wire logic                         out_valid_i,
  input  wire logic                         out_stall_i,
  input  wire logic [ntg_pkg::SAMPLE_W-1:0] sample_i,
  output int unsigned                       fail_count_o,
  output int unsigned                       pending_o
);

  import ntg_pkg::*;

  localparam int unsigned REPORT_MAX = 10;
  localparam logic [63:0] HZ_TO_STEP_MUL = 64'd628;
  localparam logic [63:0] HZ_TO_STEP_DIV = 64'd500000;
  localparam logic [63:0] ONE_Q  = 64'd1 << FRAC_BITS;
  // Phase beyond which the quadrant turns (1.56).
  localparam logic [63:0] TURN_Q = (64'd156 << FRAC_BITS) / 64'd100;
  // Above 2.5 the cubic term exceeds x, so the quarter wave is zero.
  localparam logic [63:0] BIG_Q  = (64'd5 << FRAC_BITS) / 64'd2;

  // Predicted tone state.
  logic [QUAD_W-1:0] quad;
  logic [IDX_W-1:0]  ramp_count;
  logic [63:0]       phase_step;
  logic [FREQ_W-1:0] tone_hz;
  logic [KEY_W-1:0]  last_key;
  logic [VEL_W-1:0]  loudness;

  logic [SAMPLE_W-1:0] expected_samples[$];
  int unsigned         mismatches;

  // Lowest-octave frequency in whole Hz for each semitone.
  function automatic logic [SEMI_W-1:0] octave_base_hz(input logic [SEMI_IDX_W-1:0] semi);
    logic [SEMI_W-1:0] hz;
    case (semi)
      4'd0:    hz = 6'd32;
      4'd1:    hz = 6'd34;
      4'd2:    hz = 6'd36;
      4'd3:    hz = 6'd38;
      4'd4:    hz = 6'd41;
      4'd5:    hz = 6'd43;
      4'd6:    hz = 6'd46;
      4'd7:    hz = 6'd49;
      4'd8:    hz = 6'd51;
      4'd9:    hz = 6'd55;
      4'd10:   hz = 6'd58;
      default: hz = 6'd61;
    endcase
    return hz;
  endfunction

  // Phase step per tick for a tone frequency: f * 6.28 / 5000 in fixed point.
  function automatic logic [63:0] step_for_freq(input logic [FREQ_W-1:0] hz);
    return ((64'(hz) * HZ_TO_STEP_MUL) << FRAC_BITS) / HZ_TO_STEP_DIV;
  endfunction

  // First quarter of the sine as x - x^3/6, clamped to 0..1.
  function automatic logic [63:0] quarter_wave(input logic [63:0] x);
    logic [63:0] sq;
    logic [63:0] cube;
    logic [63:0] sixth;
    if (x > BIG_Q) return 64'd0;
    sq    = (x * x) >> FRAC_BITS;
    cube  = (sq * x) >> FRAC_BITS;
    sixth = cube / 64'd6;
    if (sixth >= x) return 64'd0;
    if (x - sixth > ONE_Q) return ONE_Q;
    return x - sixth;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    logic [63:0]         x;
    logic [63:0]         p;
    logic [63:0]         biased;
    logic [63:0]         scaled;
    logic [31:0]         wide_hz;
    logic [SAMPLE_W-1:0] want;
    if (!rst_ni) begin
      quad       = '0;
      ramp_count = '0;
      phase_step = step_for_freq(FREQ_W'(RESET_HZ));
      tone_hz    = FREQ_W'(1);
      last_key   = '0;
      loudness   = '0;
      expected_samples.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // Each result beat must match the oldest predicted sample.
      if (out_valid_i && !out_stall_i) begin
        if (expected_samples.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("unexpected sample beat: got %0d, none expected", sample_i);
        end else begin
          want = expected_samples.pop_front();
          if (sample_i !== want) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("sample mismatch: expected %0d, got %0d", want, sample_i);
          end
        end
      end

      // Advance the predicted state on every accepted input beat.
      if (in_valid_i && !in_stall_i) begin
        if (op_i == OP_NOTE) begin
          if (velocity_i != '0) last_key = key_i;
          if (key_i == last_key) begin
            loudness = velocity_i;
            wide_hz  = 32'(octave_base_hz(SEMI_IDX_W'(key_i % NOTE_PER_OCT)));
            tone_hz  = FREQ_W'(wide_hz << (key_i / NOTE_PER_OCT));
          end
          phase_step = step_for_freq(tone_hz);
        end else begin
          x = phase_step * 64'(ramp_count);
          p = quarter_wave(x);
          // Build the other three quarters by symmetry, offset by one.
          case (quad)
            2'd0:    biased = ONE_Q + p;
            2'd1:    biased = ONE_Q + (ONE_Q - p);
            2'd2:    biased = ONE_Q - p;
            default: biased = p;
          endcase
          scaled = ((biased * 64'(LEVEL_GAIN) * 64'(loudness)) >> FRAC_BITS) >> OUT_SHIFT;
          want = (scaled > 64'(SAMPLE_MAX)) ? SAMPLE_W'(SAMPLE_MAX) : scaled[SAMPLE_W-1:0];
          expected_samples.push_back(want);
          if (x > TURN_Q) begin
            quad       = quad + 1'b1;
            ramp_count = '0;
          end
          ramp_count = ramp_count + 1'b1;
        end
      end

      fail_count_o <= mismatches;
      pending_o    <= expected_samples.size();
    end
  end

endmodule

`default_nettype wire

[tb/sv/tb_note_driven_sine_tone_generator.sv]
`default_nettype none

module tb_note_driven_sine_tone_generator;

  import ntg_pkg::*;

  localparam int unsigned FRAC         = 16;
  localparam int unsigned RANDOM_BEATS = 1700;
  localparam int unsigned WATCHDOG_MAX = 2000;
  localparam int unsigned HOLD_AFTER   = 300;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned DRAIN_CYCLES = 64;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [OP_W-1:0]     op;
  logic [KEY_W-1:0]    key;
  logic [VEL_W-1:0]    velocity;
  logic                out_valid;
  logic                out_stall;
  logic [SAMPLE_W-1:0] sample;

  int unsigned fail_count;
  int unsigned pending;

  // Idle modes of both sides and the key the block currently holds.
  logic             send_idle;
  logic             recv_idle;
  logic [KEY_W-1:0] held;

  note_driven_sine_tone_generator #(
    .FRAC_BITS(FRAC)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .op_i       (op),
    .key_i      (key),
    .velocity_i (velocity),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .sample_o   (sample)
  );

  tone_sample_checker #(
    .FRAC_BITS(FRAC)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .op_i        (op),
    .key_i       (key),
    .velocity_i  (velocity),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .sample_i    (sample),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Offers one input beat, after a random gap in send_idle mode, and waits until it is taken.
  task automatic offer_beat(input logic [OP_W-1:0] kind, input logic [KEY_W-1:0] k,
                            input logic [VEL_W-1:0] v);
    int unsigned gap;
    gap = send_idle ? $urandom_range(0, 4) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    op       <= kind;
    key      <= k;
    velocity <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (kind == OP_NOTE && v != '0) held = k;
  endtask

  task automatic play_ticks(input int unsigned count);
    repeat (count) offer_beat(OP_TICK, KEY_W'($urandom), VEL_W'($urandom));
  endtask

  // Result side: random stall before each beat in recv_idle mode, plus one long
  // hold-off that lets the block fill up and stall its input.
  initial begin : receiver
    int unsigned stall_left;
    int unsigned hold_left;
    int unsigned taken;
    stall_left = 0;
    hold_left  = 0;
    taken      = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
      @(posedge clk);
      if (out_valid && !out_stall) begin
        taken++;
        if (taken % 40 == 0) recv_idle = ($urandom_range(0, 2) != 0);
        stall_left = recv_idle ? $urandom_range(0, 4) : 0;
        if (taken == HOLD_AFTER) hold_left = HOLD_CYCLES;
      end
    end
  end

  // Ends the run when no beat moves on either channel for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < WATCHDOG_MAX) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int unsigned sent;
    int unsigned choice;
    logic [KEY_W-1:0] k;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    op        = OP_NOTE;
    key       = '0;
    velocity  = '0;
    out_stall = 1'b0;
    send_idle = 1'b1;
    recv_idle = 1'b1;
    held      = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: reset tone, release of a key not held, lowest and
    // highest keys, release of the held key, and phases in the cubic range,
    // where the cube cancels x, and beyond 2.5 where quadrants turn each tick.
    play_ticks(1);
    offer_beat(OP_NOTE, 7'd5, 7'd0);
    play_ticks(2);
    offer_beat(OP_NOTE, 7'd0, 7'd127);
    play_ticks(4);
    offer_beat(OP_NOTE, 7'd127, 7'd1);
    play_ticks(2);
    offer_beat(OP_NOTE, 7'd127, 7'd0);
    play_ticks(1);
    offer_beat(OP_NOTE, 7'd40, 7'd127);
    play_ticks(3);
    offer_beat(OP_NOTE, 7'd69, 7'd90);
    play_ticks(2);
    offer_beat(OP_NOTE, 7'd71, 7'd127);
    play_ticks(2);

    // Random part: mostly a note followed by a run of ticks, favoring low
    // keys whose slow phase walks through every quadrant; some releases and
    // some arbitrary beats.
    sent = 0;
    while (sent < RANDOM_BEATS) begin
      send_idle = ($urandom_range(0, 3) != 0);
      choice = $urandom_range(0, 9);
      if (choice < 7) begin
        k = ($urandom_range(0, 2) != 0) ? KEY_W'($urandom_range(0, 35))
                                         : KEY_W'($urandom_range(0, 127));
        offer_beat(OP_NOTE, k, VEL_W'($urandom_range(1, 127)));
        choice = $urandom_range(4, 80);
        play_ticks(choice);
        sent += choice + 1;
      end else if (choice < 9) begin
        k = ($urandom_range(0, 1) != 0) ? held : KEY_W'($urandom_range(0, 127));
        offer_beat(OP_NOTE, k, '0);
        choice = $urandom_range(1, 10);
        play_ticks(choice);
        sent += choice + 1;
      end else begin
        choice = $urandom_range(1, 6);
        repeat (choice) begin
          offer_beat(OP_W'($urandom_range(0, 1)), KEY_W'($urandom), VEL_W'($urandom));
        end
        sent += choice;
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

[note_driven_sine_tone_generator.f]
rtl/core/ntg_pkg.sv
rtl/core/ntg_front.sv
rtl/core/ntg_queue.sv
rtl/core/ntg_div.sv
rtl/core/ntg_back.sv
rtl/core/note_driven_sine_tone_generator.sv
tb/sv/tone_sample_checker.sv
tb/sv/tb_note_driven_sine_tone_generator.sv
